/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Clocked on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/jqir_pkg.sv */
// Package for the job queue with positional removal: field widths,
// opcodes, status codes, record and result types. No dependencies.
package jqir_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int SERVERS_DEF = 3;

    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int PRI_W = 8;
    localparam int TU_W  = 16;
    localparam int LN_W  = 16;
    localparam int OCC_W = 5;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_REM = 2'd1,
        OP_SRV = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        M_HOLD,
        M_LOAD,
        M_ROT,
        M_SHIFT,
        M_SERVE
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT_A,
        S_POP,
        S_ROT_B,
        S_SERVE
    } t_state;

    typedef struct packed {
        logic [PRI_W-1:0]        pri;
        logic [TU_W-1:0]         time_units;
        logic signed [LN_W-1:0]  lines;
    } t_rec;

    typedef struct packed {
        t_status           status;
        t_rec              rec;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } t_res;

endpackage

/* hw/rtl/jqir_if.sv */
// Command and result channel interfaces of the job queue.
// Depends on jqir_pkg for field widths.
interface jqir_in_if;
    import jqir_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic [PRI_W-1:0]        in_priority;
    logic [TU_W-1:0]         in_time_units;
    logic signed [LN_W-1:0]  in_lines;

    modport source (output valid, opcode, position, in_priority, in_time_units, in_lines,
                    input ready);
    modport sink   (input valid, opcode, position, in_priority, in_time_units, in_lines,
                    output ready);
endinterface

interface jqir_out_if;
    import jqir_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [PRI_W-1:0]        out_priority;
    logic [TU_W-1:0]         out_time_units;
    logic signed [LN_W-1:0]  out_lines;
    logic [OCC_W-1:0]        occupancy;
    logic                    last;

    modport source (output valid, status, out_priority, out_time_units, out_lines,
                    occupancy, last, input ready);
    modport sink   (input valid, status, out_priority, out_time_units, out_lines,
                    occupancy, last, output ready);
endinterface

/* hw/rtl/job_queue_indexed_remove.sv */
// Ordered job queue of DEPTH records held in a chain of cells, with enqueue at the
// tail, removal at a 1-based position and a service step over the first SERVERS
// records. A remove rotates the chain one place per cycle until the target reaches
// the head, pops it and rotates back. A service step updates the served records when
// the command is taken and then emits one result per cycle while the pending
// register is free. Results pass through a pending register and an output register,
// so the next command is taken while the previous result waits downstream.
// Depends on jqir_pkg, jqir_if and jqir_cell.
module job_queue_indexed_remove #(
    parameter int DEPTH   = jqir_pkg::DEPTH_DEF,
    parameter int SERVERS = jqir_pkg::SERVERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jqir_in_if.sink      i_cmd,
    jqir_out_if.source   o_res
);
    import jqir_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int SW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_cnt, n_cnt;
    logic [SW-1:0]   r_k, n_k;
    t_res            r_res, r_out;
    logic            r_res_v, r_out_v;

    t_mode           w_mode;
    t_op             w_op;
    t_rec            w_load;
    t_rec            w_rec  [DEPTH];
    t_rec            w_next [DEPTH];
    t_rec            w_srv  [SERVERS];
    t_res            w_res_d;
    logic            w_res_we;
    logic            w_res_take;
    logic            w_res_free;
    logic            w_accept;
    logic            w_badpos;
    logic            w_srv_last;
    logic [PW-1:0]   w_pos;

    assign w_res_take  = r_res_v && (!r_out_v || o_res.ready);
    assign w_res_free  = !r_res_v || w_res_take;
    assign i_cmd.ready = (r_state == S_IDLE) && w_res_free;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_op     = t_op'(i_cmd.opcode);
    assign w_pos    = PW'(i_cmd.position);
    assign w_badpos = (w_pos == '0) || (w_pos > PW'(r_count));
    assign w_load   = '{pri: i_cmd.in_priority, time_units: i_cmd.in_time_units,
                        lines: i_cmd.in_lines};

    always_comb begin
        if (int'(r_count) < SERVERS) begin
            w_srv_last = (int'(r_k) == int'(r_count) - 1);
        end else begin
            w_srv_last = (int'(r_k) == SERVERS - 1);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_tail
            assign w_next[g] = w_rec[0];
        end else begin : g_body
            assign w_next[g] = w_rec[g + 1];
        end

        jqir_cell #(
            .DEPTH   (DEPTH),
            .SERVERS (SERVERS),
            .INDEX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode),
            .i_count (r_count),
            .i_load  (w_load),
            .i_next  (w_next[g]),
            .i_head  (w_rec[0]),
            .o_rec   (w_rec[g])
        );
    end

    for (genvar j = 0; j < SERVERS; j++) begin : g_srv
        if (j < DEPTH) begin : g_tap
            assign w_srv[j] = w_rec[j];
        end else begin : g_none
            assign w_srv[j] = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && r_count != '0) begin
                    if (w_op == OP_REM && !w_badpos) n_state = S_ROT_A;
                    if (w_op == OP_SRV)              n_state = S_SERVE;
                end
            end
            S_ROT_A: begin
                if (r_cnt == '0) n_state = S_POP;
            end
            S_POP: begin
                if (w_res_free) n_state = S_ROT_B;
            end
            S_ROT_B: begin
                if (r_cnt == '0) n_state = S_IDLE;
            end
            S_SERVE: begin
                if (w_res_free && w_srv_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_mode    = M_HOLD;
        w_res_we  = 1'b0;
        w_res_d   = '0;
        w_res_d.occupancy = OCC_W'(r_count);
        w_res_d.last      = 1'b1;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_k       = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_ENQ: begin
                            w_res_we = 1'b1;
                            if (r_count == FULL_CNT) begin
                                w_res_d.status = ST_FULL;
                            end else begin
                                w_mode  = M_LOAD;
                                n_count = r_count + 1'b1;
                                w_res_d.occupancy = OCC_W'(r_count + 1'b1);
                            end
                        end
                        OP_REM: begin
                            if (r_count == '0) begin
                                w_res_we       = 1'b1;
                                w_res_d.status = ST_EMPTY;
                            end else if (w_badpos) begin
                                w_res_we       = 1'b1;
                                w_res_d.status = ST_BADPOS;
                            end else begin
                                n_idx = IW'(w_pos - 1'b1);
                                n_cnt = IW'(w_pos - 1'b1);
                            end
                        end
                        OP_SRV: begin
                            if (r_count == '0) begin
                                w_res_we       = 1'b1;
                                w_res_d.status = ST_EMPTY;
                            end else begin
                                w_mode = M_SERVE;
                                n_k    = '0;
                            end
                        end
                        default: w_res_we = 1'b1;
                    endcase
                end
            end
            S_ROT_A, S_ROT_B: begin
                if (r_cnt != '0) begin
                    w_mode = M_ROT;
                    n_cnt  = r_cnt - 1'b1;
                end
            end
            S_POP: begin
                if (w_res_free) begin
                    w_res_we          = 1'b1;
                    w_res_d.rec       = w_rec[0];
                    w_res_d.occupancy = OCC_W'(r_count - 1'b1);
                    w_mode            = M_SHIFT;
                    n_count           = r_count - 1'b1;
                    n_cnt             = IW'(r_count - 1'b1 - CW'(r_idx));
                end
            end
            S_SERVE: begin
                if (w_res_free) begin
                    w_res_we     = 1'b1;
                    w_res_d.rec  = w_srv[r_k];
                    w_res_d.last = w_srv_last;
                    n_k          = r_k + 1'b1;
                end
            end
            default: w_mode = M_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_k     <= '0;
            r_res_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            if (w_res_we) begin
                r_res_v <= 1'b1;
            end else if (w_res_take) begin
                r_res_v <= 1'b0;
            end
            if (w_res_take) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we)   r_res <= w_res_d;
        if (w_res_take) r_out <= r_res;
    end

    assign o_res.valid          = r_out_v;
    assign o_res.status         = r_out.status;
    assign o_res.out_priority   = r_out.rec.pri;
    assign o_res.out_time_units = r_out.rec.time_units;
    assign o_res.out_lines      = r_out.rec.lines;
    assign o_res.occupancy      = r_out.occupancy;
    assign o_res.last           = r_out.last;

endmodule

/* hw/rtl/jqir_cell.sv */
// One queue slot of the cell chain: holds a record, loads, rotates, shifts
// and serves under the mode broadcast from the top level. Depends on jqir_pkg.
module jqir_cell #(
    parameter int DEPTH   = jqir_pkg::DEPTH_DEF,
    parameter int SERVERS = jqir_pkg::SERVERS_DEF,
    parameter int INDEX   = 0
) (
    input  logic                            i_clk,
    input  jqir_pkg::t_mode                 i_mode,
    input  logic [$clog2(DEPTH + 1)-1:0]    i_count,
    input  jqir_pkg::t_rec                  i_load,
    input  jqir_pkg::t_rec                  i_next,
    input  jqir_pkg::t_rec                  i_head,
    output jqir_pkg::t_rec                  o_rec
);
    import jqir_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    function automatic logic signed [LN_W-1:0] lines_dec2(input logic signed [LN_W-1:0] l);
        logic [LN_W:0] d;
        d = {l[LN_W-1], l} - (LN_W + 1)'(2);
        if (d[LN_W] != d[LN_W-1]) begin
            return {1'b1, {(LN_W - 1){1'b0}}};
        end
        return d[LN_W-1:0];
    endfunction

    always_comb begin
        n_rec = r_rec;
        case (i_mode)
            M_LOAD: begin
                if (INDEX == int'(i_count)) n_rec = i_load;
            end
            M_ROT: begin
                if (INDEX + 1 < int'(i_count)) begin
                    n_rec = i_next;
                end else if (INDEX + 1 == int'(i_count)) begin
                    n_rec = i_head;
                end
            end
            M_SHIFT: begin
                if (INDEX + 1 < int'(i_count)) n_rec = i_next;
            end
            M_SERVE: begin
                if (INDEX < SERVERS && INDEX < int'(i_count)) begin
                    n_rec.lines = lines_dec2(r_rec.lines);
                end
            end
            default: n_rec = r_rec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

/* hw/rtl/jqir_chk.sv */
// Port-level checker for the job queue, bound to the top level.
// Depends on jqir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jqir_chk #(
    parameter int DEPTH = jqir_pkg::DEPTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [jqir_pkg::ST_W-1:0]           i_status,
    input logic [jqir_pkg::PRI_W-1:0]          i_priority,
    input logic [jqir_pkg::TU_W-1:0]           i_time_units,
    input logic signed [jqir_pkg::LN_W-1:0]    i_lines,
    input logic [jqir_pkg::OCC_W-1:0]          i_occupancy,
    input logic                                i_last
);
    import jqir_pkg::*;

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // an error result stands alone
    `ASSERT_NOW(a_err_last, i_out_valid && i_status != ST_OK, i_last)
    // an error result carries no record
    `ASSERT_NOW(a_err_zero, i_out_valid && i_status != ST_OK,
                i_priority == '0 && i_time_units == '0 && i_lines == '0)
    `ASSERT_NOW(a_occ_max, i_out_valid, int'(i_occupancy) <= DEPTH)

endmodule

bind job_queue_indexed_remove jqir_chk #(
    .DEPTH (DEPTH)
) u_jqir_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_priority   (o_res.out_priority),
    .i_time_units (o_res.out_time_units),
    .i_lines      (o_res.out_lines),
    .i_occupancy  (o_res.occupancy),
    .i_last       (o_res.last)
);

/* tb/jqir_checker.sv */
`timescale 1ns / 100ps
// Checker for the job queue: watches the command and result channels, keeps its own
// copy of the queue, predicts every result and compares it field by field.
// Depends on jqir_pkg and jqir_if.
module jqir_checker #(
    parameter int DEPTH   = jqir_pkg::DEPTH_DEF,
    parameter int SERVERS = jqir_pkg::SERVERS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jqir_in_if    i_cmd,
    jqir_out_if   i_res,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_count
);
    import jqir_pkg::*;

    localparam t_rec NO_REC = '0;

    t_rec jobs [DEPTH];
    int   job_count;
    int   fails;
    t_res due_results [$];

    initial begin
        job_count    = 0;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_count      = 0;
    end

    task automatic queue_result(t_status st, t_rec r, logic fin);
        t_res e;
        e.status    = st;
        e.rec       = r;
        e.occupancy = OCC_W'(job_count);
        e.last      = fin;
        due_results.push_back(e);
    endtask

    task automatic apply_command(t_op op, int pos, t_rec r);
        t_rec taken;
        int   n;
        int   v;
        case (op)
            OP_ENQ: begin
                if (job_count >= DEPTH) begin
                    queue_result(ST_FULL, NO_REC, 1'b1);
                end else begin
                    jobs[job_count] = r;
                    job_count++;
                    queue_result(ST_OK, NO_REC, 1'b1);
                end
            end
            OP_REM: begin
                if (job_count == 0) begin
                    queue_result(ST_EMPTY, NO_REC, 1'b1);
                end else if (pos == 0 || pos > job_count) begin
                    queue_result(ST_BADPOS, NO_REC, 1'b1);
                end else begin
                    taken = jobs[pos-1];
                    for (int i = pos - 1; i + 1 < job_count; i++) begin
                        jobs[i] = jobs[i+1];
                    end
                    job_count--;
                    queue_result(ST_OK, taken, 1'b1);
                end
            end
            OP_SRV: begin
                if (job_count == 0) begin
                    queue_result(ST_EMPTY, NO_REC, 1'b1);
                end else begin
                    n = (job_count < SERVERS) ? job_count : SERVERS;
                    for (int k = 0; k < n; k++) begin
                        v = int'(jobs[k].lines) - 2;
                        if (v < -32768) begin
                            v = -32768;
                        end
                        jobs[k].lines = LN_W'(v);
                        queue_result(ST_OK, jobs[k], k == n - 1);
                    end
                end
            end
            default: begin
                queue_result(ST_OK, NO_REC, 1'b1);
            end
        endcase
    endtask

    task automatic match_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rec r;
        t_res e;
        if (!i_rst_n) begin
            due_results.delete();
            job_count = 0;
        end else begin
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1) begin
                r.pri        = i_cmd.in_priority;
                r.time_units = i_cmd.in_time_units;
                r.lines      = i_cmd.in_lines;
                apply_command(t_op'(i_cmd.opcode), int'(i_cmd.position), r);
            end
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (due_results.size() == 0) begin
                    $error("result with no command outstanding: status %0d", i_res.status);
                    fails++;
                end else begin
                    e = due_results.pop_front();
                    match_field("status", e.status, i_res.status);
                    match_field("out_priority", e.rec.pri, i_res.out_priority);
                    match_field("out_time_units", e.rec.time_units, i_res.out_time_units);
                    match_field("out_lines", e.rec.lines, i_res.out_lines);
                    match_field("occupancy", e.occupancy, i_res.occupancy);
                    match_field("last", e.last, i_res.last);
                end
            end
        end
        o_pending    = due_results.size();
        o_count      = job_count;
        o_fail_count = fails;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the job queue testbench: clock, reset, command stimulus and result back-pressure.
// Depends on jqir_pkg, jqir_if, jqir_checker and job_queue_indexed_remove.
module testbench;
    import jqir_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int SERVERS    = SERVERS_DEF;
    localparam int RAND_ITEMS = 120;
    localparam int CALM_ITEMS = 20;
    localparam int SETTLE     = 2 * DEPTH + 12;
    localparam int LIMIT      = 200000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   held;
    int   cycle_count;
    int   gap_pct;
    int   stall_pct;
    int   sent;

    jqir_in_if  cmd ();
    jqir_out_if res ();

    job_queue_indexed_remove #(.DEPTH(DEPTH), .SERVERS(SERVERS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_res   (res)
    );

    jqir_checker #(.DEPTH(DEPTH), .SERVERS(SERVERS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_count      (held)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // hold ready low in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        res.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res.ready <= 1'b0;
                stall_left--;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                res.ready <= 1'b0;
                stall_left = $urandom_range(19, 1) - 1;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    function automatic t_rec rand_job();
        t_rec r;
        r.pri        = PRI_W'($urandom);
        r.time_units = TU_W'($urandom);
        if ($urandom_range(3) == 0) begin
            r.lines = LN_W'(-32768 + $urandom_range(5));
        end else begin
            r.lines = LN_W'($urandom);
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(bit in_range);
        if (in_range && held > 0) begin
            return POS_W'($urandom_range(held, 1));
        end else if ($urandom_range(1) == 0) begin
            return '0;
        end else begin
            return POS_W'($urandom_range(31, held + 1));
        end
    endfunction

    function automatic logic [POS_W-1:0] any_position();
        return POS_W'($urandom_range(31));
    endfunction

    // call at a falling edge; returns at the falling edge after the item is taken
    task automatic issue_command(t_op op, logic [POS_W-1:0] pos, t_rec r);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(negedge i_clk);
        end
        cmd.valid         <= 1'b1;
        cmd.opcode        <= op;
        cmd.position      <= pos;
        cmd.in_priority   <= r.pri;
        cmd.in_time_units <= r.time_units;
        cmd.in_lines      <= r.lines;
        @(posedge i_clk);
        while (cmd.ready !== 1'b1) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        cmd.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic pick_rates(bit calm);
        case (calm ? 0 : $urandom_range(2))
            0: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            1: begin
                gap_pct   = 15;
                stall_pct = 5;
            end
            default: begin
                gap_pct   = 45;
                stall_pct = 15;
            end
        endcase
    endtask

    initial begin
        int   roll;
        t_rec none;
        none              = '0;
        sent              = 0;
        gap_pct           = 0;
        stall_pct         = 0;
        i_rst_n           = 1'b0;
        cmd.valid         = 1'b0;
        cmd.opcode        = OP_ENQ;
        cmd.position      = '0;
        cmd.in_priority   = '0;
        cmd.in_time_units = '0;
        cmd.in_lines      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_pct   = 20;
        stall_pct = 10;
        issue_command(OP_REM, 5'd1, none);
        issue_command(OP_SRV, 5'd0, none);
        issue_command(OP_NOP, 5'd31, '{pri: 8'hFF, time_units: 16'hFFFF, lines: 16'shFFFF});
        issue_command(OP_ENQ, 5'd0, '{pri: 8'h00, time_units: 16'h0000, lines: 16'sh8000});
        issue_command(OP_ENQ, 5'd31, '{pri: 8'hFF, time_units: 16'hFFFF, lines: 16'sh7FFF});
        issue_command(OP_ENQ, 5'd10, '{pri: 8'h5A, time_units: 16'hA5A5, lines: 16'sh8001});
        issue_command(OP_ENQ, 5'd21, '{pri: 8'hA5, time_units: 16'h5A5A, lines: 16'sh0000});
        issue_command(OP_SRV, 5'd0, none);
        issue_command(OP_REM, 5'd0, none);
        issue_command(OP_REM, 5'd5, none);
        issue_command(OP_REM, 5'd31, none);
        issue_command(OP_REM, 5'd4, none);
        issue_command(OP_REM, 5'd1, none);
        issue_command(OP_SRV, 5'd0, none);
        issue_command(OP_ENQ, 5'd0, '{pri: 8'h01, time_units: 16'h0001, lines: 16'sh0001});
        issue_command(OP_REM, 5'd2, none);
        issue_command(OP_NOP, 5'd0, none);
        issue_command(OP_SRV, 5'd0, none);
        issue_command(OP_REM, 5'd1, none);
        issue_command(OP_SRV, 5'd0, none);
        issue_command(OP_REM, 5'd1, none);
        issue_command(OP_SRV, 5'd0, none);
        wait_results_drained();

        while (sent < RAND_ITEMS) begin
            pick_rates(sent >= RAND_ITEMS - CALM_ITEMS);
            case ($urandom_range(3))
                0: begin
                    while (held < DEPTH) begin
                        if ($urandom_range(4) == 0) begin
                            issue_command(OP_SRV, any_position(), rand_job());
                        end else begin
                            issue_command(OP_ENQ, any_position(), rand_job());
                        end
                    end
                    repeat ($urandom_range(3, 1)) begin
                        issue_command(OP_ENQ, any_position(), rand_job());
                    end
                end
                1: begin
                    while (held > 0) begin
                        roll = $urandom_range(99);
                        if (roll < 75) begin
                            issue_command(OP_REM, pick_position(1'b1), rand_job());
                        end else if (roll < 85) begin
                            issue_command(OP_REM, pick_position(1'b0), rand_job());
                        end else begin
                            issue_command(OP_SRV, any_position(), rand_job());
                        end
                    end
                    issue_command($urandom_range(1) ? OP_REM : OP_SRV, any_position(), rand_job());
                end
                default: begin
                    repeat ($urandom_range(20, 8)) begin
                        roll = $urandom_range(99);
                        if (roll < 35) begin
                            issue_command(OP_ENQ, any_position(), rand_job());
                        end else if (roll < 65) begin
                            issue_command(OP_REM, pick_position($urandom_range(4) != 0),
                                          rand_job());
                        end else if (roll < 90) begin
                            issue_command(OP_SRV, any_position(), rand_job());
                        end else begin
                            issue_command(OP_NOP, any_position(), rand_job());
                        end
                    end
                end
            endcase
            if ($urandom_range(3) == 0) begin
                wait_results_drained();
            end
        end

        gap_pct   = 0;
        stall_pct = 0;
        wait_results_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
